// ----- hdl/mfq_pkg.sv -----
package mfq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [IDX_W:0]   DEPTH_X   = (IDX_W + 1)'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
        logic [63:0] space;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic load;        // latch the input word and clear the result
        logic rd_head;     // read logical entry 0
        logic rd_tail;     // read logical entry count-1, index := count-1
        logic step;        // read logical entry index-1, index := index-1
        logic shift;       // move read entry to index+1
        logic place_next;  // write new entry at index+1
        logic place_head;  // write new entry at logical 0
        logic ins_done;    // count := count+1
        logic pop;         // capture read entry as result, drop head
        logic emit;        // hand result to the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_mode;
        logic count_zero;
        logic full;
        logic idx_zero;
        logic shift_ok;    // read entry key <= new key
        logic out_free;
    } t_status;

endpackage

// ----- hdl/mfq_if.sv -----
interface mfq_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] host_address;
    logic [15:0] host_port;
    logic [63:0] host_space;

    modport source(output valid, output mode, output host_address, output host_port,
                   output host_space, input ready);
    modport sink(input valid, input mode, input host_address, input host_port,
                 input host_space, output ready);
endinterface

interface mfq_out_if;
    logic        valid;
    logic        ready;
    logic        popped_valid;
    logic [31:0] popped_address;
    logic [15:0] popped_port;
    logic [63:0] popped_free_space;
    logic        insert_dropped;
    logic        queue_empty;
    logic [4:0]  entry_count;

    modport source(output valid, output popped_valid, output popped_address,
                   output popped_port, output popped_free_space, output insert_dropped,
                   output queue_empty, output entry_count, input ready);
    modport sink(input valid, input popped_valid, input popped_address,
                 input popped_port, input popped_free_space, input insert_dropped,
                 input queue_empty, input entry_count, output ready);
endinterface

// ----- hdl/max_free_space_host_queue_core.sv -----
// max-first host queue: up to QUEUE_DEPTH hosts sorted by free space, largest first
// input channel i_in: mode 0 inserts (host_address, host_port, host_space),
//   mode 1 pops the host with the most free space; among equal keys the newest wins
// output channel o_out: one word per input word, with the popped host (if any),
//   the dropped flag for an insert into a full list, and the count after the step
// entries sit in a ring buffer memory with one write and one registered read port
// an insert walks from the tail toward the head, moving one entry per cycle
// through that port pair, then writes the new host (into an empty list it writes
// the head directly, into a full list it writes nothing); a pop reads the head, then
// captures it as the result, and a pop of an empty list goes straight to finish
// one word is in flight at a time; the next input is taken once the result sits
// in the output register
// when o_out.ready is low the finished word waits in the output register and the
// following result holds in the controller until the register frees
// synchronous reset (i_rst_n low) empties the list; memory contents are not cleared
module max_free_space_host_queue_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mfq_in_if.sink    i_in,
    mfq_out_if.source o_out
);
    import mfq_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    assign i_in.ready = in_ready;

    mfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mfq_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cmd    (cmd),
        .o_status (status)
    );

endmodule

// ----- hdl/mfq_ctrl.sv -----
module mfq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  mfq_pkg::t_status i_status,
    output mfq_pkg::t_cmd    o_cmd
);
    import mfq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_PLACE = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.in_mode == MODE_POP) begin
                        if (i_status.count_zero) begin
                            n_state = S_FIN;
                        end else begin
                            o_cmd.rd_head = 1'b1;
                            n_state       = S_POP;
                        end
                    end else begin
                        priority if (i_status.full) begin
                            n_state = S_FIN;
                        end else if (i_status.count_zero) begin
                            n_state = S_PLACE;
                        end else begin
                            o_cmd.rd_tail = 1'b1;
                            n_state       = S_WALK;
                        end
                    end
                end
            end
            S_WALK: begin
                // walk from the tail toward the head, moving entries with key <= new key
                if (i_status.shift_ok) begin
                    o_cmd.shift = 1'b1;
                    if (i_status.idx_zero) begin
                        n_state = S_PLACE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end else begin
                    o_cmd.place_next = 1'b1;
                    o_cmd.ins_done   = 1'b1;
                    n_state          = S_FIN;
                end
            end
            S_PLACE: begin
                o_cmd.place_head = 1'b1;
                o_cmd.ins_done   = 1'b1;
                n_state          = S_FIN;
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/mfq_dp.sv -----
module mfq_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mfq_in_if.sink           i_in,
    mfq_out_if.source        o_out,
    input  mfq_pkg::t_cmd    i_cmd,
    output mfq_pkg::t_status o_status
);
    import mfq_pkg::*;

    // ring buffer: logical entry k lives at (head + k) mod depth
    function automatic logic [IDX_W-1:0] f_phys(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] ofs);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, ofs};
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[IDX_W-1:0];
    endfunction

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rd_data;

    logic [IDX_W-1:0] r_head;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    t_entry           r_new;

    logic [IDX_W-1:0] cnt_m1;
    logic [IDX_W-1:0] idx_m1;
    logic [IDX_W-1:0] idx_p1;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;

    // result register
    logic        r_res_valid;
    logic [31:0] r_res_addr;
    logic [15:0] r_res_port;
    logic [63:0] r_res_space;
    logic        r_res_drop;

    logic             r_out_valid;
    logic             r_out_pvalid;
    logic [31:0]      r_out_addr;
    logic [15:0]      r_out_port;
    logic [63:0]      r_out_space;
    logic             r_out_drop;
    logic             r_out_empty;
    logic [4:0]       r_out_count;
    logic [CNT_W+4:0] count_ext;

    assign cnt_m1    = IDX_W'(r_count - 1'b1);
    assign idx_m1    = r_idx - 1'b1;
    assign idx_p1    = r_idx + 1'b1;
    assign count_ext = {5'd0, r_count};

    always_comb begin
        rd_en   = i_cmd.rd_head | i_cmd.rd_tail | i_cmd.step;
        rd_addr = r_head;
        priority if (i_cmd.rd_tail) begin
            rd_addr = f_phys(r_head, cnt_m1);
        end else if (i_cmd.step) begin
            rd_addr = f_phys(r_head, idx_m1);
        end else begin
            rd_addr = r_head;
        end

        wr_en   = i_cmd.shift | i_cmd.place_next | i_cmd.place_head;
        wr_data = i_cmd.shift ? r_rd_data : r_new;
        wr_addr = i_cmd.place_head ? r_head : f_phys(r_head, idx_p1);

        n_idx = r_idx;
        priority if (i_cmd.rd_tail) begin
            n_idx = cnt_m1;
        end else if (i_cmd.step) begin
            n_idx = idx_m1;
        end else begin
            n_idx = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load) begin
            r_new.addr  <= i_in.host_address;
            r_new.port  <= i_in.host_port;
            r_new.space <= i_in.host_space;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.ins_done) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.pop) begin
                r_count <= r_count - 1'b1;
                r_head  <= (r_head == IDX_LAST) ? '0 : r_head + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res_valid <= 1'b0;
            r_res_addr  <= '0;
            r_res_port  <= '0;
            r_res_space <= '0;
            r_res_drop  <= (i_in.mode == MODE_INSERT) && (r_count == CNT_FULL);
        end else if (i_cmd.pop) begin
            r_res_valid <= 1'b1;
            r_res_addr  <= r_rd_data.addr;
            r_res_port  <= r_rd_data.port;
            r_res_space <= r_rd_data.space;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_pvalid <= r_res_valid;
            r_out_addr   <= r_res_addr;
            r_out_port   <= r_res_port;
            r_out_space  <= r_res_space;
            r_out_drop   <= r_res_drop;
            r_out_empty  <= (r_count == '0);
            r_out_count  <= count_ext[4:0];
        end
    end

    assign o_status.in_mode    = i_in.mode;
    assign o_status.count_zero = (r_count == '0);
    assign o_status.full       = (r_count == CNT_FULL);
    assign o_status.idx_zero   = (r_idx == '0);
    assign o_status.shift_ok   = (r_rd_data.space <= r_new.space);
    assign o_status.out_free   = !r_out_valid || o_out.ready;

    assign o_out.valid             = r_out_valid;
    assign o_out.popped_valid      = r_out_pvalid;
    assign o_out.popped_address    = r_out_addr;
    assign o_out.popped_port       = r_out_port;
    assign o_out.popped_free_space = r_out_space;
    assign o_out.insert_dropped    = r_out_drop;
    assign o_out.queue_empty       = r_out_empty;
    assign o_out.entry_count       = r_out_count;

endmodule
